### rtl/stt_pkg.sv
// Shared types and constants for the software timer table.
// Used by stt_slot_alu and software_timer_table.
`default_nettype none
package stt_pkg;

   localparam int DefaultSlots = 8;
   localparam int MaxEvents    = 8;
   localparam int EvCntW       = $clog2(MaxEvents + 1);
   localparam int KindW        = 2;
   localparam int ReceptorW    = 16;
   localparam int TicksW       = 32;
   localparam int SlotW        = 6;
   localparam int RamW         = 2 * TicksW + ReceptorW;

   typedef enum logic [KindW-1:0] {
      KIND_TICK     = 2'd0,
      KIND_ONE_SHOT = 2'd1,
      KIND_PERIODIC = 2'd2,
      KIND_DESTROY  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic                 enabled;
      logic                 one_shot;
      logic [TicksW-1:0]    period;
      logic [TicksW-1:0]    remaining;
      logic [ReceptorW-1:0] receptor;
   } slot_entry_type;

   typedef struct packed {
      logic           hit;
      logic           fire;
      logic           write;
      slot_entry_type entry;
   } alu_out_type;

   typedef struct packed {
      logic                 event_valid;
      logic [ReceptorW-1:0] event_receptor;
      logic [SlotW-1:0]     slot;
      logic                 ok;
      logic                 last;
   } result_type;

endpackage
`default_nettype wire

### rtl/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module stt_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                          rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/stt_slot_alu.sv
// Shared per-slot unit: decrement and reload for tick, claim for create,
// receptor match for destroy. Depends on stt_pkg.
`default_nettype none
module stt_slot_alu (
   input  stt_pkg::kind_type                   kind,
   input  wire logic [stt_pkg::ReceptorW-1:0]  receptor_id,
   input  wire logic [stt_pkg::TicksW-1:0]     timeout_ticks,
   input  stt_pkg::slot_entry_type             entry,
   output stt_pkg::alu_out_type                result
);
   import stt_pkg::*;

   logic [TicksW-1:0] dec;

   assign dec = entry.remaining - TicksW'(1);

   always_comb begin
      result       = '0;
      result.entry = entry;
      case (kind)
         KIND_TICK: begin
            if (entry.enabled && (entry.remaining != '0)) begin
               result.write           = 1'b1;
               result.entry.remaining = dec;
               if (dec == '0) begin
                  result.fire = 1'b1;
                  if (entry.one_shot) begin
                     result.entry.enabled = 1'b0;
                  end else begin
                     result.entry.remaining = entry.period;
                  end
               end
            end
         end
         KIND_ONE_SHOT, KIND_PERIODIC: begin
            if (!entry.enabled) begin
               result.hit             = 1'b1;
               result.write           = 1'b1;
               result.entry.enabled   = 1'b1;
               result.entry.one_shot  = (kind == KIND_ONE_SHOT);
               result.entry.period    = (kind == KIND_ONE_SHOT) ? '0 : timeout_ticks;
               result.entry.remaining = timeout_ticks;
               result.entry.receptor  = receptor_id;
            end
         end
         KIND_DESTROY: begin
            if (entry.receptor == receptor_id) begin
               result.hit             = 1'b1;
               result.write           = 1'b1;
               result.entry.enabled   = 1'b0;
               result.entry.period    = '0;
               result.entry.remaining = '0;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end
endmodule
`default_nettype wire

### rtl/software_timer_table.sv
// Software timer table: walks the slots one at a time through a shared unit.
// Each slot takes a RAM read state, then an update state. A tick walks every
// slot; create or destroy stops at the first slot that it claims or matches.
// One item at a time; a stalled result output can hold the walk.
// Reset clears control state and marks every slot unwritten (reads as zero);
// there is no clearing pass. Depends on stt_pkg, stt_ram, stt_slot_alu.
`default_nettype none
module software_timer_table #(
   parameter int SLOTS = stt_pkg::DefaultSlots
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [stt_pkg::KindW-1:0]       req_kind,
   input  wire logic [stt_pkg::ReceptorW-1:0]   req_receptor_id,
   input  wire logic [stt_pkg::TicksW-1:0]      req_timeout_ticks,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_event_valid,
   output logic [stt_pkg::ReceptorW-1:0]        rsp_event_receptor,
   output logic [stt_pkg::SlotW-1:0]            rsp_slot,
   output logic                                 rsp_ok,
   output logic                                 rsp_last
);
   import stt_pkg::*;

   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type             state_ff, state_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [EvCntW-1:0]     ev_cnt_ff, ev_cnt_in;
   kind_type              kind_ff, kind_in;
   logic [ReceptorW-1:0]  rec_ff, rec_in;
   logic [TicksW-1:0]     ticks_ff, ticks_in;
   logic                  pend_v_ff, pend_v_in;
   result_type            pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;
   logic [SLOTS-1:0]      en_ff, en_in;
   logic [SLOTS-1:0]      os_ff, os_in;
   logic [SLOTS-1:0]      written_ff, written_in;

   logic                  rd_en;
   logic                  wr_en;
   logic [RamW-1:0]       rd_data;
   logic [RamW-1:0]       wr_data;
   slot_entry_type        entry;
   alu_out_type           alu;
   logic                  out_free;
   logic                  last_slot;
   logic                  emit;
   logic                  hold;
   logic                  load_out;
   logic                  out_last;
   result_type            event_item;

   stt_ram #(
      .Width (RamW),
      .Depth (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      entry          = '0;
      entry.enabled  = en_ff[idx_ff];
      entry.one_shot = os_ff[idx_ff];
      if (written_ff[idx_ff]) begin
         {entry.period, entry.remaining, entry.receptor} = rd_data;
      end
   end

   stt_slot_alu u_alu (
      .kind          (kind_ff),
      .receptor_id   (rec_ff),
      .timeout_ticks (ticks_ff),
      .entry         (entry),
      .result        (alu)
   );

   assign wr_data   = {alu.entry.period, alu.entry.remaining, alu.entry.receptor};
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = (idx_ff == IdxW'(SLOTS - 1));
   assign emit      = (kind_ff == KIND_TICK) && alu.fire &&
                      (ev_cnt_ff < EvCntW'(MaxEvents));
   assign hold      = emit && pend_v_ff && !out_free;

   always_comb begin
      event_item                = '0;
      event_item.event_valid    = 1'b1;
      event_item.event_receptor = entry.receptor;
      event_item.slot           = SlotW'(idx_ff);
      event_item.ok             = 1'b1;
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      ev_cnt_in  = ev_cnt_ff;
      kind_in    = kind_ff;
      rec_in     = rec_ff;
      ticks_in   = ticks_ff;
      pend_v_in  = pend_v_ff;
      pend_in    = pend_ff;
      en_in      = en_ff;
      os_in      = os_ff;
      written_in = written_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      load_out   = 1'b0;
      out_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = kind_type'(req_kind);
               rec_in    = req_receptor_id;
               ticks_in  = req_timeout_ticks;
               idx_in    = '0;
               ev_cnt_in = '0;
               pend_v_in = 1'b0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!hold) begin
               if (alu.write) begin
                  wr_en              = 1'b1;
                  en_in[idx_ff]      = alu.entry.enabled;
                  os_in[idx_ff]      = alu.entry.one_shot;
                  written_in[idx_ff] = 1'b1;
               end
               if (kind_ff == KIND_TICK) begin
                  if (emit) begin
                     load_out  = pend_v_ff;
                     pend_v_in = 1'b1;
                     pend_in   = event_item;
                     ev_cnt_in = ev_cnt_ff + EvCntW'(1);
                  end
                  if (last_slot) begin
                     state_in = ST_FLUSH;
                  end else begin
                     idx_in   = idx_ff + IdxW'(1);
                     state_in = ST_READ;
                  end
               end else if (alu.hit) begin
                  pend_v_in    = 1'b1;
                  pend_in      = '0;
                  pend_in.slot = SlotW'(idx_ff);
                  pend_in.ok   = 1'b1;
                  state_in     = ST_FLUSH;
               end else if (last_slot) begin
                  pend_v_in = 1'b1;
                  pend_in   = '0;
                  state_in  = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + IdxW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               load_out  = 1'b1;
               out_last  = 1'b1;
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (load_out) begin
         rsp_in      = pend_ff;
         rsp_in.last = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         en_ff        <= '0;
         os_ff        <= '0;
         written_ff   <= '0;
         idx_ff       <= '0;
         ev_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         en_ff        <= en_in;
         os_ff        <= os_in;
         written_ff   <= written_in;
         idx_ff       <= idx_in;
         ev_cnt_ff    <= ev_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rec_ff   <= rec_in;
      ticks_ff <= ticks_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_valid    = rsp_ff.event_valid;
   assign rsp_event_receptor = rsp_ff.event_receptor;
   assign rsp_slot           = rsp_ff.slot;
   assign rsp_ok             = rsp_ff.ok;
   assign rsp_last           = rsp_ff.last;

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_READ && idx_ff == '0))
      else $error("accepted item did not start a walk at slot zero");

   a_event_limit: assert property (@(posedge clock) disable iff (reset)
      ev_cnt_ff <= EvCntW'(MaxEvents))
      else $error("event count beyond limit");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_v_ff)
      else $error("pending result left behind at idle");

   a_single_result_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && kind_ff != KIND_TICK) |-> pend_v_ff)
      else $error("create or destroy reached flush without a result");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (load_out && out_last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("final result did not return to idle");
endmodule
`default_nettype wire
